// ===== hw/rtl/lsg_pkg.sv =====
// Shared types, constants and the gray-code threshold table of the grayscale pixel block.
package lsg_pkg;

	localparam int CH_W   = 8;
	localparam int SUM_W  = 24;
	localparam int CODE_W = 8;
	localparam int CODES  = 256;

	// Luminance weights as 16-bit fractions; they sum to 65536.
	localparam logic [15:0] W_RED   = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE  = 16'd4732;

	// Fixed-point constants used to build the threshold table.
	localparam logic [63:0] FULL_SCALE = 64'd255 * 64'd65536;
	localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
	localparam int          LINEAR_TOP = 10;
	localparam logic [63:0] LIN_NUM    = 64'd6553600;
	localparam logic [63:0] LIN_DEN    = 64'd1292;
	localparam logic [63:0] SRGB_Q     = 64'd269025;

	typedef logic [SUM_W-1:0] thresh_t [CODES];

	// One item moving down the cell chain.
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [CODE_W-1:0] code;
		logic [CH_W-1:0]   alpha;
	} item_t;

	// Fifth power in Q30 with truncated products.
	function automatic logic [63:0] pow5_q30(input logic [63:0] r);
		logic [63:0] a;
		logic [63:0] b;
		a = (r * r) >> 30;
		b = (a * a) >> 30;
		return (b * r) >> 30;
	endfunction

	// Largest Q30 value in [0,1] whose fifth power does not exceed w.
	function automatic logic [63:0] root5_q30(input logic [63:0] w);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		lo = 64'd0;
		hi = ONE_Q30;
		while (lo < hi) begin
			mid = lo + ((hi - lo + 64'd1) >> 1);
			if (pow5_q30(mid) <= w) begin
				lo = mid;
			end else begin
				hi = mid - 64'd1;
			end
		end
		return lo;
	endfunction

	// Linear-domain threshold of every gray code, evaluated at elaboration.
	function automatic thresh_t build_thresh();
		thresh_t     tab;
		logic [63:0] p;
		logic [63:0] x;
		logic [63:0] w;
		logic [63:0] r;
		logic [63:0] t;
		tab[0] = '0;
		for (int c = 1; c < CODES; c++) begin
			if (c <= LINEAR_TOP) begin
				tab[c] = SUM_W'((64'(c) * LIN_NUM + LIN_DEN - 64'd1) / LIN_DEN);
			end else begin
				p = 64'd1000 * 64'(c) + 64'd14025;
				x = ((p << 30) + (SRGB_Q >> 1)) / SRGB_Q;
				if (x > ONE_Q30) begin
					x = ONE_Q30;
				end
				w = (x * x) >> 30;
				r = root5_q30(w);
				t = (w * r) >> 30;
				tab[c] = SUM_W'((t * FULL_SCALE + ONE_Q30 - 64'd1) >> 30);
			end
		end
		return tab;
	endfunction

	localparam thresh_t THRESH = build_thresh();

endpackage

// ===== hw/rtl/lsg_weight.sv =====
// Front stage: weighted luminance sum of the three color channels.
module lsg_weight
	import lsg_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	input  logic [CH_W-1:0] alpha_in,
	output logic            out_valid,
	output item_t           out_item
);

	logic [SUM_W-1:0] sum;
	logic             valid_s1;
	item_t            item_s1;

	// Three constant multiplies and two adds; the result never exceeds 255*65536.
	assign sum = SUM_W'(32'(red) * 32'(W_RED) + 32'(green) * 32'(W_GREEN)
		+ 32'(blue) * 32'(W_BLUE));

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the stage; the code starts at zero for the first cell.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.sum   <= sum;
			item_s1.code  <= '0;
			item_s1.alpha <= alpha_in;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

// ===== hw/rtl/lsg_cell.sv =====
// One cell of the code search: decides a single bit of the gray code.
module lsg_cell
	import lsg_pkg::*;
#(
	parameter int BIT = 7
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  out_valid,
	output item_t out_item
);

	logic [CODE_W-1:0] trial;
	logic              reach;
	logic              valid_s1;
	item_t             item_s1;

	// Try this bit set; keep it when the sum reaches the trial code's threshold.
	assign trial = in_item.code | (CODE_W'(1) << BIT);
	assign reach = in_item.sum >= THRESH[trial];

	// Valid flag of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload handed to the next cell.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.sum   <= in_item.sum;
			item_s1.code  <= reach ? trial : in_item.code;
			item_s1.alpha <= in_item.alpha;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

// ===== hw/rtl/luma_srgb_grayscale_pixel.sv =====
// Top level of the grayscale pixel block: weight stage followed by a chain of search cells.
//
// Each RGBA item is reduced to an sRGB-encoded gray level with alpha copied through.
// The block takes one item per clock while s_tready is high; each item passes a registered
// weighted-sum stage, then eight cells, each a table lookup and a 24-bit
// compare that settles one bit of the gray code from the top bit down. The last cell
// is the output register; while it holds an item that is not taken, the whole chain
// holds and s_tready is low. There are no configuration registers.
module luma_srgb_grayscale_pixel
	import lsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // red[7:0], green[15:8], blue[23:16], alpha_in[31:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // gray[7:0], alpha_out[15:8]
);

	logic  adv;
	logic  valid_c [CODE_W+1];
	item_t item_c  [CODE_W+1];

	// The chain moves whenever the output is empty or being taken.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Weighted sum stage.
	lsg_weight u_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (s_tvalid),
		.red      (s_tdata[7:0]),
		.green    (s_tdata[15:8]),
		.blue     (s_tdata[23:16]),
		.alpha_in (s_tdata[31:24]),
		.out_valid(valid_c[0]),
		.out_item (item_c[0])
	);

	// Search cells, most significant code bit first.
	for (genvar i = 0; i < CODE_W; i++) begin : g_cell
		lsg_cell #(
			.BIT(CODE_W - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_valid (valid_c[i]),
			.in_item  (item_c[i]),
			.out_valid(valid_c[i+1]),
			.out_item (item_c[i+1])
		);
	end

	assign m_tvalid = valid_c[CODE_W];
	assign m_tdata  = {item_c[CODE_W].alpha, item_c[CODE_W].code};

	// The luminance sum never exceeds full scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_c[0] |-> item_c[0].sum <= SUM_W'(FULL_SCALE))
		else $error("luminance sum above full scale");

	// The delivered code is the largest one whose threshold the sum reaches.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (item_c[CODE_W].sum >= THRESH[item_c[CODE_W].code])
			&& (item_c[CODE_W].code == 8'hFF
				|| item_c[CODE_W].sum < THRESH[item_c[CODE_W].code + 8'd1]))
		else $error("gray code does not match its threshold interval");

	// A stalled chain keeps the item in the weight stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_c[0]) && (!valid_c[0] || $stable(item_c[0])))
		else $error("weight stage changed while the chain was held");

	// An item accepted at the input appears at the weight stage next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_c[0] && item_c[0].alpha == $past(s_tdata[31:24]))
		else $error("accepted item lost at the weight stage");

endmodule

// ===== bench/lsg_checker.sv =====
// Scoreboard for the grayscale pixel block: predicts gray and alpha per pixel and checks results.
module lsg_checker
	import lsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // red[7:0], green[15:8], blue[23:16], alpha_in[31:24]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // gray[7:0], alpha_out[15:8]
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CODE_W-1:0] gray;
		logic [CH_W-1:0]   alpha;
	} gray_expect_t;

	// Lowest weighted sum that reaches each gray code.
	logic [SUM_W-1:0] code_floor [CODES];

	gray_expect_t pending_gray [$];

	// Fifth power of a Q30 value, every product truncated back to Q30.
	function automatic logic [63:0] fifth_q30(input logic [63:0] v);
		logic [63:0] sq;
		logic [63:0] quad;
		sq   = (v * v) >> 30;
		quad = (sq * sq) >> 30;
		return (quad * v) >> 30;
	endfunction

	// Largest Q30 value up to one whose fifth power stays at or below w.
	// The fifth power rises with its argument, so the root is settled bit by bit.
	function automatic logic [63:0] fifth_root_q30(input logic [63:0] w);
		logic [63:0] root;
		logic [63:0] trial;
		root = 64'd0;
		for (int b = 30; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial <= ONE_Q30 && fifth_q30(trial) <= w) begin
				root = trial;
			end
		end
		return root;
	endfunction

	// Linear-light sum at which a gray code starts.
	function automatic logic [SUM_W-1:0] floor_of_code(input int code);
		logic [63:0] enc;
		logic [63:0] sq;
		logic [63:0] lin;
		if (code == 0) begin
			return '0;
		end
		// Low codes sit on the straight segment of the curve.
		if (code <= LINEAR_TOP) begin
			return SUM_W'((64'(code) * 64'd6553600 + 64'd1291) / 64'd1292);
		end
		// Above it, raise the decoded level to the power 2.4 as x^2 times x^(2/5).
		enc = ((64'(1000 * code + 14025) << 30) + 64'd134512) / 64'd269025;
		if (enc > ONE_Q30) begin
			enc = ONE_Q30;
		end
		sq  = (enc * enc) >> 30;
		lin = (sq * fifth_root_q30(sq)) >> 30;
		return SUM_W'((lin * FULL_SCALE + ONE_Q30 - 64'd1) >> 30);
	endfunction

	// Gray code of one pixel: how many code floors the weighted sum reaches.
	function automatic gray_expect_t predict_gray(input logic [31:0] px);
		gray_expect_t res;
		logic [SUM_W-1:0] luma;
		int level;
		luma = SUM_W'(32'd13933 * px[7:0] + 32'd46871 * px[15:8] + 32'd4732 * px[23:16]);
		level = 0;
		for (int c = 1; c < CODES; c++) begin
			if (luma >= code_floor[c]) begin
				level++;
			end
		end
		res.gray  = CODE_W'(level);
		res.alpha = px[31:24];
		return res;
	endfunction

	initial begin
		mismatches  = 0;
		outstanding = 0;
		for (int c = 0; c < CODES; c++) begin
			code_floor[c] = floor_of_code(c);
		end
	end

	// Check each taken result against the oldest prediction, then log new pixels.
	always @(posedge clk) begin
		gray_expect_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_gray.size() == 0) begin
					$error("unexpected result: gray %0d alpha_out %0d",
						m_tdata[7:0], m_tdata[15:8]);
					mismatches++;
				end else begin
					want = pending_gray.pop_front();
					if (m_tdata[7:0] !== want.gray) begin
						$error("gray: expected %0d, got %0d", want.gray, m_tdata[7:0]);
						mismatches++;
					end
					if (m_tdata[15:8] !== want.alpha) begin
						$error("alpha_out: expected %0d, got %0d", want.alpha, m_tdata[15:8]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				pending_gray.push_back(predict_gray(s_tdata));
			end
			outstanding <= pending_gray.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the grayscale pixel block: clock, reset, pixel stimulus and the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_PER_PHASE = 150;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // red[7:0], green[15:8], blue[23:16], alpha_in[31:24]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // gray[7:0], alpha_out[15:8]

	int mismatches;
	int outstanding;
	int src_idle_pct;
	int sink_idle_pct;
	int stall_cycles;

	luma_srgb_grayscale_pixel DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lsg_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] rgba(input int r, input int g, input int b, input int a);
		return {8'(a), 8'(b), 8'(g), 8'(r)};
	endfunction

	// Search for a color whose weighted sum is exactly the target, green first from a start.
	function automatic bit pixel_for_sum(input int unsigned target, input int g_start,
		output logic [23:0] rgb);
		int unsigned part;
		int unsigned rest;
		int g;
		rgb = '0;
		for (int i = 0; i < 256; i++) begin
			g = (g_start + i) % 256;
			for (int r = 0; r < 256; r++) begin
				part = 46871 * g + 13933 * r;
				if (part > target) begin
					break;
				end
				rest = target - part;
				if (rest % 4732 == 0 && rest / 4732 < 256) begin
					rgb = {8'(rest / 4732), 8'(g), 8'(r)};
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// Channel value biased toward the ends of the range.
	function automatic int edge_channel();
		case ($urandom_range(4))
			0: return 0;
			1: return 1;
			2: return 254;
			3: return 255;
			default: return $urandom_range(255);
		endcase
	endfunction

	// Offer one pixel, idling first at the current rate, and hold it until taken.
	task automatic send_pixel(input logic [31:0] px);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Pixel whose sum lands on a code floor or just below it.
	task automatic send_boundary_pixel(input int code, input int below, input int alpha);
		logic [23:0] rgb;
		if (pixel_for_sum(chk.code_floor[code] - below, $urandom_range(255), rgb)) begin
			send_pixel({8'(alpha), rgb});
		end
	endtask

	task automatic send_random_pixels(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				send_boundary_pixel($urandom_range(1, 255), $urandom_range(1),
					$urandom_range(255));
			end else if (pick < 18) begin
				send_pixel(rgba(edge_channel(), edge_channel(), edge_channel(),
					edge_channel()));
			end else begin
				send_pixel($urandom);
			end
		end
	endtask

	// Result side: back-pressure at the current rate, changed at each falling edge.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= sink_idle_pct) && arst_n;
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("luma_srgb_grayscale_pixel regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		stall_cycles  = 0;
		src_idle_pct  = 38;
		sink_idle_pct = 47;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pixels: black, white, single channels, alpha patterns, grays.
		send_pixel(rgba(0, 0, 0, 0));
		send_pixel(rgba(255, 255, 255, 255));
		send_pixel(rgba(255, 0, 0, 8'hAA));
		send_pixel(rgba(0, 255, 0, 8'h55));
		send_pixel(rgba(0, 0, 255, 8'h0F));
		send_pixel(rgba(1, 0, 0, 8'hF0));
		send_pixel(rgba(0, 1, 0, 1));
		send_pixel(rgba(0, 0, 1, 254));
		send_pixel(rgba(1, 1, 1, 128));
		send_pixel(rgba(128, 128, 128, 127));
		send_pixel(rgba(254, 254, 254, 0));

		// Exact code boundaries: sums right on a floor and one below it, at both segments.
		send_boundary_pixel(1, 0, 3);
		send_boundary_pixel(1, 1, 252);
		send_boundary_pixel(10, 0, 17);
		send_boundary_pixel(10, 1, 200);
		send_boundary_pixel(11, 0, 64);
		send_boundary_pixel(11, 1, 99);
		send_boundary_pixel(128, 0, 255);
		send_boundary_pixel(128, 1, 0);
		send_boundary_pixel(254, 0, 31);
		send_boundary_pixel(254, 1, 224);

		send_random_pixels(RANDOM_PER_PHASE - 20);

		src_idle_pct  = 47;
		sink_idle_pct = 38;
		send_random_pixels(RANDOM_PER_PHASE);

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		send_random_pixels(RANDOM_PER_PHASE);

		s_tvalid <= 1'b0;
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("luma_srgb_grayscale_pixel regression: pass");
		end else begin
			$display("luma_srgb_grayscale_pixel regression: fail");
		end
		$finish;
	end

endmodule
